// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion shorthands, clocked on aclk and disabled while aresetn is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SEV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SEV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sev_pkg.sv -----
// ---------------------------------------------------------------------------
// sev_pkg
// widths, register codes and bundle types for the eddy viscosity pipeline
// ---------------------------------------------------------------------------
package sev_pkg;

    localparam int GRAD_W   = 32;
    localparam int N_GRAD   = 9;
    localparam int CS_W     = 16;
    localparam int CSL_W    = CS_W + GRAD_W;
    localparam int CSL2_W   = 2 * CSL_W;
    localparam int INV_W    = 64;
    localparam int ROOT_W   = INV_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int VISC_W   = 48;
    localparam int DSUM_W   = 64;
    localparam int OSUM_W   = 66;
    localparam int SUM_W    = 67;
    localparam int IN_W     = (N_GRAD + 1) * GRAD_W;
    localparam int OUT_W    = VISC_W + INV_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MODEL_CONSTANT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_DIMENSIONAL = 1'b1;

    localparam logic [CS_W-1:0] CS_RESET = 16'd11796;

    // values that ride alongside the root extraction
    typedef struct packed {
        logic [CSL_W-1:0] csl;
        logic [INV_W-1:0] inv;
        logic             sat;
    } sev_side_t;

    typedef struct packed {
        logic [VISC_W-1:0] visc;
        logic [INV_W-1:0]  inv;
        logic              sat;
    } sev_result_t;

endpackage

// ----- hdl/smagorinsky_eddy_viscosity.sv -----
// ---------------------------------------------------------------------------
// smagorinsky_eddy_viscosity
// subgrid eddy viscosity per mesh cell: cs^2 * l^2 * sqrt(2 * Sij * Sij)
// ---------------------------------------------------------------------------
// Input stream s_*: one beat per cell, nine gradient words and the filter
// length. Output stream m_*: viscosity and strain invariant in tdata, the
// saturation flag in tuser. cfg_we/cfg_index/cfg_wdata write the model
// constant (index 0) and the 2D mode bit (index 1); write only while idle.
// Throughput is one cell per cycle while the output skid is empty. An accepted
// input beat reaches m_tvalid through 4 strain stages, 32 square-root stages
// (one root bit each), 4 scaling stages and the output register.
// Reset clears every valid bit and the output skid, and loads cs = 11796
// (about 0.18) with three-dimensional mode.
// When the receiver stalls, the output register holds its beat and the next
// finished beat drops into a one-entry skid register; while the skid is full
// the whole pipeline and s_tready hold, so nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module smagorinsky_eddy_viscosity
    import sev_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // grad_xx, grad_xy, grad_xz, grad_yx, grad_yy, grad_yz, grad_zx, grad_zy,
    // grad_zz, filter_length
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // eddy_viscosity, strain_invariant
    output logic [OUT_W-1:0]      m_tdata,
    // saturated
    output logic                  m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [CS_W-1:0] cs_reg, cs_next;
    logic            two_d_reg, two_d_next;

    logic              en;
    logic              strain_valid;
    sev_side_t         strain_side;
    logic              root_valid;
    logic [ROOT_W-1:0] root;
    sev_side_t         root_side;
    logic              res_valid;
    sev_result_t       res;

    logic        out_valid_reg, out_valid_next;
    sev_result_t out_reg, out_next;
    logic        skid_valid_reg, skid_valid_next;
    sev_result_t skid_reg, skid_next;
    logic        out_free;

    always_comb begin
        cs_next    = cs_reg;
        two_d_next = two_d_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_MODEL_CONSTANT:  cs_next    = cfg_wdata;
                CFG_TWO_DIMENSIONAL: two_d_next = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs_reg    <= CS_RESET;
            two_d_reg <= 1'b0;
        end else begin
            cs_reg    <= cs_next;
            two_d_reg <= two_d_next;
        end
    end

    // pipeline moves whenever the skid entry is free
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    sev_strain #(
        .FRAC_BITS (FRAC_BITS)
    ) u_strain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .cs        (cs_reg),
        .two_d     (two_d_reg),
        .out_valid (strain_valid),
        .out_side  (strain_side)
    );

    sev_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (strain_valid),
        .in_side   (strain_side),
        .out_valid (root_valid),
        .out_root  (root),
        .out_side  (root_side)
    );

    sev_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (root_valid),
        .in_root   (root),
        .in_side   (root_side),
        .out_valid (res_valid),
        .out_res   (res)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        out_free        = !out_valid_reg || m_tready;
        if (skid_valid_reg) begin
            if (out_free) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (res_valid) begin
            if (out_free) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end else if (out_free) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.inv, out_reg.visc};
    assign m_tuser  = out_reg.sat;

    `SEV_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid holds a beat while output is empty")
    `SEV_ASSERT_SAME(a_skid_fill_on_stall, $rose(skid_valid_reg), $past(out_valid_reg && !m_tready), "skid filled without an output stall")
    `SEV_ASSERT_NEXT(a_pipe_holds, !en && res_valid, res_valid, "stalled pipeline dropped its last beat")

endmodule

// ----- hdl/sev_strain.sv -----
// ---------------------------------------------------------------------------
// sev_strain
// four stage front end: strain magnitudes, squares, sums and scaled invariant
// ---------------------------------------------------------------------------
module sev_strain
    import sev_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [IN_W-1:0]    in_data,
    input  logic [CS_W-1:0]    cs,
    input  logic               two_d,
    output logic               out_valid,
    output sev_side_t          out_side
);

    localparam int INV_LSH = (2 * FRAC_BITS <= ROOT_W) ? ROOT_W - 2 * FRAC_BITS : 0;
    localparam int INV_RSH = (2 * FRAC_BITS > ROOT_W) ? 2 * FRAC_BITS - ROOT_W : 0;
    localparam int S_W     = SUM_W + INV_LSH;

    function automatic logic [GRAD_W-1:0] mag_diag(input logic [GRAD_W-1:0] x);
        mag_diag = x[GRAD_W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [GRAD_W:0] mag_pair(input logic [GRAD_W:0] x);
        mag_pair = x[GRAD_W] ? (~x + 1'b1) : x;
    endfunction

    logic [GRAD_W-1:0] g [N_GRAD];
    logic [GRAD_W:0]   pair [3];
    logic [GRAD_W-1:0] fl;

    // stage 1
    logic              v1_reg;
    logic [GRAD_W-1:0] d_abs_reg  [3];
    logic [GRAD_W-1:0] d_abs_next [3];
    logic [GRAD_W:0]   o_abs_reg  [3];
    logic [GRAD_W:0]   o_abs_next [3];
    logic [CSL_W-1:0]  csl1_reg;
    logic [CSL_W-1:0]  csl1_next;
    // stage 2
    logic              v2_reg;
    logic [2*GRAD_W-1:0] dsq_reg  [3];
    logic [2*GRAD_W-1:0] dsq_next [3];
    logic [OSUM_W-1:0] osq_reg  [3];
    logic [OSUM_W-1:0] osq_next [3];
    logic [CSL_W-1:0]  csl2_reg;
    // stage 3
    logic              v3_reg;
    logic [DSUM_W-1:0] dsum_reg;
    logic [DSUM_W-1:0] dsum_next;
    logic [OSUM_W-1:0] osum_reg;
    logic [OSUM_W-1:0] osum_next;
    logic [CSL_W-1:0]  csl3_reg;
    // stage 4
    logic              v4_reg;
    sev_side_t         side_reg;
    sev_side_t         side_next;
    logic [SUM_W-1:0]  u;
    logic [S_W-1:0]    s;

    always_comb begin
        for (int i = 0; i < N_GRAD; i++) begin
            g[i] = in_data[GRAD_W*i +: GRAD_W];
        end
        fl = in_data[GRAD_W*N_GRAD +: GRAD_W];
        // order xx xy xz yx yy yz zx zy zz
        pair[0] = {g[1][GRAD_W-1], g[1]} + {g[3][GRAD_W-1], g[3]};
        pair[1] = {g[2][GRAD_W-1], g[2]} + {g[6][GRAD_W-1], g[6]};
        pair[2] = {g[5][GRAD_W-1], g[5]} + {g[7][GRAD_W-1], g[7]};
        d_abs_next[0] = mag_diag(g[0]);
        d_abs_next[1] = mag_diag(g[4]);
        d_abs_next[2] = two_d ? '0 : mag_diag(g[8]);
        o_abs_next[0] = mag_pair(pair[0]);
        o_abs_next[1] = two_d ? '0 : mag_pair(pair[1]);
        o_abs_next[2] = two_d ? '0 : mag_pair(pair[2]);
        csl1_next = cs * fl;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dsq_next[i] = d_abs_reg[i] * d_abs_reg[i];
            osq_next[i] = o_abs_reg[i] * o_abs_reg[i];
        end
    end

    assign dsum_next = dsq_reg[0] + dsq_reg[1] + dsq_reg[2];
    assign osum_next = osq_reg[0] + osq_reg[1] + osq_reg[2];

    always_comb begin
        u = {dsum_reg, 1'b0} + SUM_W'(osum_reg);
        s = (S_W'(u) << INV_LSH) >> INV_RSH;
        side_next.csl = csl3_reg;
        side_next.sat = |s[S_W-1:INV_W];
        side_next.inv = side_next.sat ? '1 : s[INV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                d_abs_reg[i] <= d_abs_next[i];
                o_abs_reg[i] <= o_abs_next[i];
                dsq_reg[i]   <= dsq_next[i];
                osq_reg[i]   <= osq_next[i];
            end
            csl1_reg <= csl1_next;
            csl2_reg <= csl1_reg;
            dsum_reg <= dsum_next;
            osum_reg <= osum_next;
            csl3_reg <= csl2_reg;
            side_reg <= side_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_side  = side_reg;

endmodule

// ----- hdl/sev_isqrt.sv -----
// ---------------------------------------------------------------------------
// sev_isqrt
// floor square root of the invariant, one root bit per pipeline stage
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sev_isqrt
    import sev_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  sev_side_t         in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output sev_side_t         out_side
);

    logic              v_reg    [ROOT_W];
    logic [INV_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] q_reg    [ROOT_W];
    sev_side_t         side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              v_in;
        logic [INV_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] q_in;
        sev_side_t         side_in;
        logic [REM_W-1:0]  acc;
        logic [REM_W-1:0]  trial;
        logic              fits;
        logic [INV_W-1:0]  rad_next;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] q_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = in_side.inv;
            assign rem_in  = '0;
            assign q_in    = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = v_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // remainder never exceeds twice the partial root, so its top two bits are zero
        assign acc      = {rem_in[REM_W-3:0], rad_in[INV_W-1 -: 2]};
        assign trial    = REM_W'({q_in, 2'b01});
        assign fits     = (acc >= trial);
        assign rem_next = fits ? (acc - trial) : acc;
        assign q_next   = {q_in[ROOT_W-2:0], fits};
        assign rad_next = {rad_in[INV_W-3:0], 2'b00};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= rad_next;
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = q_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

    `SEV_ASSERT_SAME(a_rem_bound, v_reg[ROOT_W-1], rem_reg[ROOT_W-1] <= {q_reg[ROOT_W-1], 1'b0}, "sqrt remainder above twice the root")

endmodule

// ----- hdl/sev_scale.sv -----
// ---------------------------------------------------------------------------
// sev_scale
// (cs*l)^2 times the root in partial products, then truncate and saturate
// ---------------------------------------------------------------------------
module sev_scale
    import sev_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] in_root,
    input  sev_side_t         in_side,
    output logic              out_valid,
    output sev_result_t       out_res
);

    localparam int V_W  = 4 * ROOT_W;
    localparam int VSH  = ROOT_W + 2 * FRAC_BITS;
    localparam int HI_W = CSL_W - ROOT_W;

    logic [ROOT_W-1:0] lo;
    logic [HI_W-1:0]   hi;

    // stage 1: partial squares of cs*l
    logic                 v1_reg;
    logic [2*ROOT_W-1:0]  pll_reg, pll_next;
    logic [CSL_W-1:0]     phl_reg, phl_next;
    logic [2*HI_W-1:0]    phh_reg, phh_next;
    logic [ROOT_W-1:0]    root1_reg;
    logic [INV_W-1:0]     inv1_reg;
    logic                 sat1_reg;
    // stage 2: (cs*l)^2
    logic                 v2_reg;
    logic [CSL2_W-1:0]    csl2_reg, csl2_next;
    logic [ROOT_W-1:0]    root2_reg;
    logic [INV_W-1:0]     inv2_reg;
    logic                 sat2_reg;
    // stage 3: limb products with the root
    logic                 v3_reg;
    logic [2*ROOT_W-1:0]  c_reg  [3];
    logic [2*ROOT_W-1:0]  c_next [3];
    logic [INV_W-1:0]     inv3_reg;
    logic                 sat3_reg;
    // stage 4: result
    logic                 v4_reg;
    sev_result_t          res_reg, res_next;
    logic [V_W:0]         vext;
    logic                 vsat;

    always_comb begin
        lo       = in_side.csl[ROOT_W-1:0];
        hi       = in_side.csl[CSL_W-1:ROOT_W];
        pll_next = lo * lo;
        phl_next = hi * lo;
        phh_next = hi * hi;
    end

    assign csl2_next = CSL2_W'(pll_reg) + (CSL2_W'(phl_reg) << (ROOT_W + 1))
                     + (CSL2_W'(phh_reg) << (2 * ROOT_W));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_next[i] = csl2_reg[ROOT_W*i +: ROOT_W] * root2_reg;
        end
    end

    always_comb begin
        vext = (V_W+1)'(c_reg[0]) + ((V_W+1)'(c_reg[1]) << ROOT_W)
             + ((V_W+1)'(c_reg[2]) << (2 * ROOT_W));
        vsat = |vext[V_W:VSH+VISC_W];
        res_next.visc = vsat ? '1 : vext[VSH +: VISC_W];
        res_next.inv  = inv3_reg;
        res_next.sat  = sat3_reg | vsat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pll_reg   <= pll_next;
            phl_reg   <= phl_next;
            phh_reg   <= phh_next;
            root1_reg <= in_root;
            inv1_reg  <= in_side.inv;
            sat1_reg  <= in_side.sat;
            csl2_reg  <= csl2_next;
            root2_reg <= root1_reg;
            inv2_reg  <= inv1_reg;
            sat2_reg  <= sat1_reg;
            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= c_next[i];
            end
            inv3_reg  <= inv2_reg;
            sat3_reg  <= sat2_reg;
            res_reg   <= res_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_res   = res_reg;

endmodule

// ----- tb/tb_smagorinsky_eddy_viscosity.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_smagorinsky_eddy_viscosity
// self-checking bench for the per-cell eddy viscosity pipeline
// ---------------------------------------------------------------------------
// A directed table covers zero fields, the field extremes, pure rotation, the
// two-dimensional mode, zero and full-scale constants and both saturation
// paths. Random cells follow in phases with different register settings.
// Every accepted beat that is not typed gets an expectation from an in-bench
// fixed-point model of the strain invariant, its root and the scaled viscosity;
// typed rows use their table result. Output beats are compared field by field
// in order. Both stream sides idle at random, except in one full-rate phase.
// ---------------------------------------------------------------------------
module tb_smagorinsky_eddy_viscosity;
    import sev_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_GAP   = 48;
    localparam int N_PHASES    = 8;
    localparam int PHASE_CELLS = 232;
    localparam int N_ROWS      = 19;

    localparam logic [31:0] NEG_MAX = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_ONE   = 32'h0001_0000;
    localparam logic [31:0] Q_M_ONE = 32'hFFFF_0000;
    localparam logic [31:0] L_MAX   = 32'hFFFF_FFFF;

    localparam sev_result_t NO_RESULT = '{visc: '0, inv: '0, sat: 1'b0};
    localparam sev_result_t BOTH_SAT  = '{visc: '1, inv: '1, sat: 1'b1};
    localparam sev_result_t INV_SAT   = '{visc: '0, inv: '1, sat: 1'b1};

    typedef struct packed {
        logic [CS_W-1:0]  cs;
        logic             two_d;
        logic [0:8][31:0] grads;  // xx xy xz yx yy yz zx zy zz
        logic [31:0]      len;
        logic             typed;  // use the typed result instead of the model
        sev_result_t      want;
    } cell_row_t;

    localparam cell_row_t DIR_TABLE [N_ROWS] = '{
        // reset settings
        '{16'd11796, 1'b0, '{9{32'h0}}, 32'h0, 1'b1, NO_RESULT},
        '{16'd11796, 1'b0, '{9{32'h0}}, L_MAX, 1'b1, NO_RESULT},
        '{16'd11796, 1'b0, '{9{NEG_MAX}}, L_MAX, 1'b1, BOTH_SAT},
        '{16'd11796, 1'b0, '{9{POS_MAX}}, L_MAX, 1'b1, BOTH_SAT},
        '{16'd11796, 1'b0, '{Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
          Q_ONE, 1'b0, NO_RESULT},
        // pure rotation has no strain
        '{16'd11796, 1'b0, '{32'h0, Q_ONE, 32'h0, Q_M_ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
          L_MAX, 1'b1, NO_RESULT},
        '{16'd11796, 1'b0, '{32'h0, 32'h0, POS_MAX, 32'h0, 32'h0, 32'h0, POS_MAX, 32'h0, 32'h0},
          Q_ONE, 1'b0, NO_RESULT},
        '{16'd11796, 1'b0, '{NEG_MAX, POS_MAX, NEG_MAX, POS_MAX, NEG_MAX, POS_MAX, NEG_MAX,
          POS_MAX, NEG_MAX}, 32'h1, 1'b0, NO_RESULT},
        '{16'd11796, 1'b0, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, POS_MAX},
          Q_ONE, 1'b0, NO_RESULT},
        '{16'd11796, 1'b0, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0},
          L_MAX, 1'b0, NO_RESULT},
        '{16'd11796, 1'b0, '{L_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
          L_MAX, 1'b0, NO_RESULT},
        // two-dimensional: z gradients drop out
        '{16'd11796, 1'b1, '{32'h0, 32'h0, NEG_MAX, 32'h0, 32'h0, NEG_MAX, NEG_MAX, NEG_MAX,
          NEG_MAX}, L_MAX, 1'b1, NO_RESULT},
        '{16'd11796, 1'b1, '{Q_ONE, 32'h0, POS_MAX, 32'h0, 32'h0, POS_MAX, POS_MAX, POS_MAX,
          POS_MAX}, Q_ONE, 1'b0, NO_RESULT},
        '{16'd11796, 1'b1, '{9{NEG_MAX}}, L_MAX, 1'b1, BOTH_SAT},
        // zero constant: viscosity zero, invariant still saturates
        '{16'd0, 1'b0, '{9{NEG_MAX}}, L_MAX, 1'b1, INV_SAT},
        '{16'd0, 1'b0, '{32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
          Q_ONE, 1'b0, NO_RESULT},
        // full-scale constant
        '{16'hFFFF, 1'b1, '{9{POS_MAX}}, L_MAX, 1'b1, BOTH_SAT},
        '{16'hFFFF, 1'b1, '{Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
          Q_ONE, 1'b0, NO_RESULT},
        '{16'hFFFF, 1'b1, '{32'h0, Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
          32'h0, 1'b0, NO_RESULT}
    };

    localparam logic [CS_W-1:0] PHASE_CS [N_PHASES] =
        '{16'd11796, 16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'd11796};
    localparam logic PHASE_2D [N_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    sev_result_t     pending_results [$];
    logic [CS_W-1:0] cur_cs = CS_RESET;
    logic            cur_2d = 1'b0;
    bit              quiet  = 1'b0;
    int              err_cnt   = 0;
    int              beat_cnt  = 0;
    int              cycle_cnt = 0;

    smagorinsky_eddy_viscosity uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [127:0] sq_mag(logic signed [65:0] t);
        logic [127:0] m;
        if (t < 0)
            t = -t;
        m = 128'(t);
        return m * m;
    endfunction

    // fixed-point strain invariant, root and viscosity for one cell
    function automatic sev_result_t smag_predict(logic [IN_W-1:0] cell_data,
                                                 logic [CS_W-1:0] cs, logic two_d);
        sev_result_t        res;
        logic signed [65:0] g [3][3];
        logic [127:0]       acc;
        logic [127:0]       scaled;
        logic [127:0]       prod;
        logic [63:0]        root;
        logic [63:0]        trial;
        int                 dim;
        res = NO_RESULT;
        acc = '0;
        dim = two_d ? 2 : 3;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                g[i][j] = 66'($signed(cell_data[(i * 3 + j) * GRAD_W +: GRAD_W]));
        for (int i = 0; i < dim; i++) begin
            acc = acc + (sq_mag(g[i][i]) << 1);
            for (int j = i + 1; j < dim; j++)
                acc = acc + sq_mag(g[i][j] + g[j][i]);
        end
        if (acc[127:INV_W] != '0) begin
            res.inv = '1;
            res.sat = 1'b1;
        end else begin
            res.inv = acc[INV_W-1:0];
        end
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= res.inv)
                root = trial;
        end
        scaled = cs * cell_data[IN_W-1 -: GRAD_W];
        prod = (scaled * scaled * root) >> (2 * GRAD_W);
        if (prod[127:VISC_W] != '0) begin
            res.visc = '1;
            res.sat  = 1'b1;
        end else begin
            res.visc = prod[VISC_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [IN_W-1:0] pack_cell(logic [0:8][31:0] grads, logic [31:0] len);
        logic [IN_W-1:0] d;
        for (int k = 0; k < N_GRAD; k++)
            d[k * GRAD_W +: GRAD_W] = grads[k];
        d[IN_W-1 -: GRAD_W] = len;
        return d;
    endfunction

    // mix of full range, scaled-down values and corner words
    function automatic logic [31:0] rand_word(bit signed_field);
        logic signed [31:0] w;
        w = $urandom;
        case ($urandom_range(4))
            0: ;
            1, 2: w = signed_field ? w >>> $urandom_range(31) : w >> $urandom_range(31);
            3: w = signed_field ? w >>> $urandom_range(8, 20) : w >> $urandom_range(8, 20);
            default: begin
                case ($urandom_range(3))
                    0: w = 32'h0;
                    1: w = NEG_MAX;
                    2: w = POS_MAX;
                    default: w = L_MAX;
                endcase
            end
        endcase
        return w;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        err_cnt++;
        $display("beat %0d %s: got %h expected %h", beat_cnt, what, got, want);
    endtask

    // called just after a rising edge; returns at the edge that took the beat
    task automatic send_cell(logic [IN_W-1:0] cell_data, bit typed, sev_result_t want);
        while (!quiet && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cell_data;
        do
            @(posedge aclk);
        while (!s_tready);
        pending_results.push_back(typed ? want : smag_predict(cell_data, cur_cs, cur_2d));
    endtask

    task automatic set_config(logic [CS_W-1:0] cs, logic two_d);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODEL_CONSTANT;
        cfg_wdata <= cs;
        cur_cs = cs;
        @(posedge aclk);
        // upper data bits are don't-care for the mode register
        cfg_index <= CFG_TWO_DIMENSIONAL;
        cfg_wdata <= {15'($urandom), two_d};
        cur_2d = two_d;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge aclk)
        m_tready <= aresetn && (quiet || $urandom_range(99) >= 12);

    always @(posedge aclk) begin
        sev_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("beat with nothing pending", m_tdata[63:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[VISC_W-1:0] !== want.visc)
                    flag_mismatch("eddy_viscosity", 64'(m_tdata[VISC_W-1:0]),
                                  64'(want.visc));
                if (m_tdata[OUT_W-1:VISC_W] !== want.inv)
                    flag_mismatch("strain_invariant", m_tdata[OUT_W-1:VISC_W], want.inv);
                if (m_tuser !== want.sat)
                    flag_mismatch("saturated", 64'(m_tuser), 64'(want.sat));
            end
            beat_cnt++;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [0:8][31:0] grads;
        logic [CS_W-1:0]  cs;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (DIR_TABLE[r].cs != cur_cs || DIR_TABLE[r].two_d != cur_2d)
                set_config(DIR_TABLE[r].cs, DIR_TABLE[r].two_d);
            send_cell(pack_cell(DIR_TABLE[r].grads, DIR_TABLE[r].len), DIR_TABLE[r].typed,
                      DIR_TABLE[r].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            cs = PHASE_CS[ph];
            if (ph == 3 || ph == 5)
                cs = CS_W'($urandom);
            set_config(cs, (ph == 5) ? 1'($urandom) : PHASE_2D[ph]);
            quiet = (ph == 3);
            for (int n = 0; n < PHASE_CELLS; n++) begin
                for (int k = 0; k < N_GRAD; k++)
                    grads[k] = rand_word(1'b1);
                send_cell(pack_cell(grads, rand_word(1'b0)), 1'b0, NO_RESULT);
            end
            quiet = 1'b0;
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
